// ===== hdl/rbh_pkg.sv =====
package rbh_pkg;

  localparam int FRAC_BITS = 16;
  localparam int CFG_IDX_W = 3;

  localparam logic OP_HIT   = 1'b0;
  localparam logic OP_CLAMP = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MIN_X = 3'd0,
    REG_MIN_Y = 3'd1,
    REG_MIN_Z = 3'd2,
    REG_MAX_X = 3'd3,
    REG_MAX_Y = 3'd4,
    REG_MAX_Z = 3'd5
  } reg_idx_t;

endpackage

// ===== hdl/ray_box_hit_and_clamp.sv =====
// Stages: queue slot, divider load register, COORD_WIDTH-1 divider stages, two multiply
// stages, output register. Throughput: one item per cycle unless a result waits;
// the divider is fully pipelined, one quotient bit per stage.
// The whole back pipeline holds while a result waits; a two-entry queue absorbs the front.
// Synchronous active-low reset clears all valid flags, the queue and the box registers.
module ray_box_hit_and_clamp #(
  parameter int COORD_WIDTH = 32
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [rbh_pkg::CFG_IDX_W-1:0]   cfg_idx,
  input  logic [COORD_WIDTH-1:0]          cfg_wdata,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic                            in_op,
  input  logic [COORD_WIDTH-1:0]          in_org_x,
  input  logic [COORD_WIDTH-1:0]          in_org_y,
  input  logic [COORD_WIDTH-1:0]          in_org_z,
  input  logic [COORD_WIDTH-1:0]          in_dir_x,
  input  logic [COORD_WIDTH-1:0]          in_dir_y,
  input  logic [COORD_WIDTH-1:0]          in_dir_z,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic                            out_hit,
  output logic [COORD_WIDTH-1:0]          out_near_x,
  output logic [COORD_WIDTH-1:0]          out_near_y,
  output logic [COORD_WIDTH-1:0]          out_near_z
);

  localparam int CW = COORD_WIDTH;
  localparam int EW = 12 * CW + 59;

  logic [2:0][CW-1:0] bmin_r, bmax_r;
  logic [2:0][CW-1:0] org, dir, near;
  logic [EW-1:0]      ent, head_data;
  logic               full, head_valid, pop_en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bmin_r <= '0;
      bmax_r <= '0;
    end else if (cfg_we) begin
      case (rbh_pkg::reg_idx_t'(cfg_idx))
        rbh_pkg::REG_MIN_X: bmin_r[0] <= cfg_wdata;
        rbh_pkg::REG_MIN_Y: bmin_r[1] <= cfg_wdata;
        rbh_pkg::REG_MIN_Z: bmin_r[2] <= cfg_wdata;
        rbh_pkg::REG_MAX_X: bmax_r[0] <= cfg_wdata;
        rbh_pkg::REG_MAX_Y: bmax_r[1] <= cfg_wdata;
        rbh_pkg::REG_MAX_Z: bmax_r[2] <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign org      = {in_org_z, in_org_y, in_org_x};
  assign dir      = {in_dir_z, in_dir_y, in_dir_x};
  assign in_ready = !full;

  rbh_front #(.CW(CW), .EW(EW)) u_front (
    .op   (in_op),
    .org  (org),
    .dir  (dir),
    .bmin (bmin_r),
    .bmax (bmax_r),
    .ent  (ent)
  );

  rbh_queue #(.DW(EW)) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (in_valid && in_ready),
    .push_data  (ent),
    .full       (full),
    .pop_en     (pop_en),
    .head_valid (head_valid),
    .head_data  (head_data)
  );

  rbh_back #(.CW(CW), .EW(EW)) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (head_valid),
    .head_data  (head_data),
    .pop_en     (pop_en),
    .bmin       (bmin_r),
    .bmax       (bmax_r),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_hit    (out_hit),
    .out_near   (near)
  );

  assign out_near_x = near[0];
  assign out_near_y = near[1];
  assign out_near_z = near[2];

endmodule

// ===== hdl/rbh_front.sv =====
module rbh_front #(
  parameter int CW = 32,
  parameter int EW = 12 * CW + 59
) (
  input  logic                 op,
  input  logic [2:0][CW-1:0]   org,
  input  logic [2:0][CW-1:0]   dir,
  input  logic [2:0][CW-1:0]   bmin,
  input  logic [2:0][CW-1:0]   bmax,
  output logic [EW-1:0]        ent
);

  localparam int NW = CW + rbh_pkg::FRAC_BITS;
  localparam int RW = 2 * CW + rbh_pkg::FRAC_BITS;

  typedef struct packed {
    logic               op;
    logic               in_box;
    logic [2:0][CW-1:0] near;
    logic [2:0][CW-1:0] org;
    logic [2:0][CW-1:0] dmag;
    logic [2:0]         dneg;
    logic [2:0]         face_ok;
    logic [2:0]         ovf;
    logic [2:0][NW-1:0] num;
  } ent_t;

  ent_t                e;
  logic [CW-1:0]       plane;
  logic signed [CW:0]  diff;
  logic [CW-1:0]       nmag;
  logic [NW-1:0]       num;

  always_comb begin
    e        = '0;
    plane    = '0;
    diff     = '0;
    nmag     = '0;
    num      = '0;
    e.op     = op;
    e.in_box = 1'b1;
    for (int k = 0; k < 3; k++) begin
      e.in_box = e.in_box && ($signed(org[k]) >= $signed(bmin[k]))
                          && ($signed(org[k]) <= $signed(bmax[k]));
      if ($signed(org[k]) < $signed(bmin[k])) begin
        e.near[k] = bmin[k];
      end else if ($signed(org[k]) > $signed(bmax[k])) begin
        e.near[k] = bmax[k];
      end else begin
        e.near[k] = org[k];
      end
      e.org[k]  = org[k];
      e.dneg[k] = dir[k][CW-1];
      e.dmag[k] = dir[k][CW-1] ? (CW'(0) - dir[k]) : dir[k];
      // facing plane: max bound for negative direction
      plane = e.dneg[k] ? bmax[k] : bmin[k];
      diff  = $signed({plane[CW-1], plane}) - $signed({org[k][CW-1], org[k]});
      nmag  = diff[CW] ? (CW'(0) - diff[CW-1:0]) : diff[CW-1:0];
      num   = {nmag, {rbh_pkg::FRAC_BITS{1'b0}}};
      e.num[k] = num;
      // quotient would not fit in CW-1 bits
      e.ovf[k] = RW'(num) >= (RW'(e.dmag[k]) << (CW - 1));
      // zero direction offers no face; negative nonzero t fails
      e.face_ok[k] = (dir[k] != '0) &&
                     !((diff[CW] != e.dneg[k]) && (RW'(num) >= RW'(e.dmag[k])));
    end
    ent = e;
  end

endmodule

// ===== hdl/rbh_queue.sv =====
module rbh_queue #(
  parameter int DW = 32
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  logic [DW-1:0] push_data,
  output logic          full,
  input  logic          pop_en,
  output logic          head_valid,
  output logic [DW-1:0] head_data
);

  logic [DW-1:0] mem_r [2];
  logic          wr_ptr_r, rd_ptr_r;
  logic [1:0]    cnt_r;
  logic          pop;

  assign full       = (cnt_r == 2'd2);
  assign head_valid = (cnt_r != 2'd0);
  assign head_data  = mem_r[rd_ptr_r];
  assign pop        = pop_en && head_valid;

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (push) wr_ptr_r <= ~wr_ptr_r;
      if (pop)  rd_ptr_r <= ~rd_ptr_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

// ===== hdl/rbh_back.sv =====
module rbh_back #(
  parameter int CW = 32,
  parameter int EW = 12 * CW + 59
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 head_valid,
  input  logic [EW-1:0]        head_data,
  output logic                 pop_en,
  input  logic [2:0][CW-1:0]   bmin,
  input  logic [2:0][CW-1:0]   bmax,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic                 out_hit,
  output logic [2:0][CW-1:0]   out_near
);

  localparam int FB  = rbh_pkg::FRAC_BITS;
  localparam int NW  = CW + FB;
  localparam int RW  = 2 * CW + FB;
  localparam int NS  = CW - 1;
  localparam int TLO = (CW - 1) / 2;
  localparam int THI = CW - 1 - TLO;
  localparam int PW  = 2 * CW - 1;
  localparam int XW  = 2 * CW + 2;

  typedef struct packed {
    logic               op;
    logic               in_box;
    logic [2:0][CW-1:0] near;
    logic [2:0][CW-1:0] org;
    logic [2:0][CW-1:0] dmag;
    logic [2:0]         dneg;
    logic [2:0]         face_ok;
    logic [2:0]         ovf;
    logic [2:0][NW-1:0] num;
  } ent_t;

  typedef struct packed {
    logic               op;
    logic               in_box;
    logic [2:0][CW-1:0] near;
    logic [2:0][CW-1:0] org;
    logic [2:0][CW-1:0] dmag;
    logic [2:0]         dneg;
    logic [2:0]         face_ok;
    logic [2:0]         ovf;
    logic [2:0][RW-1:0] rem;
    logic [2:0][CW-2:0] q;
  } st_t;

  typedef struct packed {
    logic                         op;
    logic                         in_box;
    logic [2:0][CW-1:0]           near;
    logic [2:0][CW-1:0]           org;
    logic [2:0]                   dneg;
    logic [2:0]                   face_ok;
    logic [2:0][1:0][TLO+CW-1:0]  pl;
    logic [2:0][1:0][THI+CW-1:0]  ph;
  } mt_t;

  typedef struct packed {
    logic                   op;
    logic                   in_box;
    logic [2:0][CW-1:0]     near;
    logic [2:0][CW-1:0]     org;
    logic [2:0]             face_ok;
    logic [2:0][1:0][XW-1:0] ps;
  } pt_t;

  logic        en;
  ent_t        he;
  st_t         st_r   [NS+1];
  st_t         st_nxt [NS+1];
  logic        vld_r  [NS+1];
  mt_t         mt_r, mt_nxt;
  logic        mt_vld_r;
  pt_t         pt_r, pt_nxt;
  logic        pt_vld_r;
  logic        hit_nxt;
  logic        out_valid_r, out_hit_r;
  logic [2:0][CW-1:0] out_near_r, near_nxt;

  assign en     = !out_valid_r || out_ready;
  assign pop_en = en;
  assign he     = ent_t'(head_data);

  always_comb begin
    st_nxt[0]         = '0;
    st_nxt[0].op      = he.op;
    st_nxt[0].in_box  = he.in_box;
    st_nxt[0].near    = he.near;
    st_nxt[0].org     = he.org;
    st_nxt[0].dmag    = he.dmag;
    st_nxt[0].dneg    = he.dneg;
    st_nxt[0].face_ok = he.face_ok;
    st_nxt[0].ovf     = he.ovf;
    for (int k = 0; k < 3; k++) begin
      st_nxt[0].rem[k] = RW'(he.num[k]);
    end
  end

  always_ff @(posedge clk) begin
    if (en) st_r[0] <= st_nxt[0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) vld_r[0] <= 1'b0;
    else if (en) vld_r[0] <= head_valid;
  end

  // restoring divider, one quotient bit per stage
  for (genvar j = 0; j < NS; j++) begin : g_div
    localparam int B = NS - 1 - j;
    logic [RW:0] sub [3];

    always_comb begin
      st_nxt[j+1] = st_r[j];
      for (int k = 0; k < 3; k++) begin
        sub[k] = {1'b0, st_r[j].rem[k]} - ({1'b0, RW'(st_r[j].dmag[k])} << B);
        if (!sub[k][RW]) begin
          st_nxt[j+1].rem[k]  = sub[k][RW-1:0];
          st_nxt[j+1].q[k][B] = 1'b1;
        end
      end
    end

    always_ff @(posedge clk) begin
      if (en) st_r[j+1] <= st_nxt[j+1];
    end

    always_ff @(posedge clk) begin
      if (!rst_n) vld_r[j+1] <= 1'b0;
      else if (en) vld_r[j+1] <= vld_r[j];
    end
  end

  // t times the other axes' direction, split in two partial products
  logic [CW-2:0] tq [3];
  always_comb begin
    mt_nxt         = '0;
    mt_nxt.op      = st_r[NS].op;
    mt_nxt.in_box  = st_r[NS].in_box;
    mt_nxt.near    = st_r[NS].near;
    mt_nxt.org     = st_r[NS].org;
    mt_nxt.dneg    = st_r[NS].dneg;
    mt_nxt.face_ok = st_r[NS].face_ok;
    for (int k = 0; k < 3; k++) begin
      tq[k] = st_r[NS].ovf[k] ? {(CW-1){1'b1}} : st_r[NS].q[k];
      for (int j = 0; j < 2; j++) begin
        mt_nxt.pl[k][j] = (TLO+CW)'(tq[k][TLO-1:0]) *
                          (TLO+CW)'(st_r[NS].dmag[(k+1+j)%3]);
        mt_nxt.ph[k][j] = (THI+CW)'(tq[k][CW-2:TLO]) *
                          (THI+CW)'(st_r[NS].dmag[(k+1+j)%3]);
      end
    end
  end

  logic [PW-1:0] prod [3][2];
  logic [PW-1:0] pm   [3][2];
  always_comb begin
    pt_nxt         = '0;
    pt_nxt.op      = mt_r.op;
    pt_nxt.in_box  = mt_r.in_box;
    pt_nxt.near    = mt_r.near;
    pt_nxt.org     = mt_r.org;
    pt_nxt.face_ok = mt_r.face_ok;
    for (int k = 0; k < 3; k++) begin
      for (int j = 0; j < 2; j++) begin
        prod[k][j] = (PW'(mt_r.ph[k][j]) << TLO) + PW'(mt_r.pl[k][j]);
        pm[k][j]   = prod[k][j] >> FB;
        pt_nxt.ps[k][j] = mt_r.dneg[(k+1+j)%3] ? (XW'(0) - XW'(pm[k][j]))
                                                : XW'(pm[k][j]);
      end
    end
  end

  logic signed [XW-1:0] lo_d [3][2];
  logic signed [XW-1:0] hi_d [3][2];
  logic                 inb  [3][2];
  always_comb begin
    hit_nxt = pt_r.in_box;
    for (int k = 0; k < 3; k++) begin
      for (int j = 0; j < 2; j++) begin
        lo_d[k][j] = $signed({{(XW-CW){bmin[(k+1+j)%3][CW-1]}}, bmin[(k+1+j)%3]}) -
                     $signed({{(XW-CW){pt_r.org[(k+1+j)%3][CW-1]}}, pt_r.org[(k+1+j)%3]});
        hi_d[k][j] = $signed({{(XW-CW){bmax[(k+1+j)%3][CW-1]}}, bmax[(k+1+j)%3]}) -
                     $signed({{(XW-CW){pt_r.org[(k+1+j)%3][CW-1]}}, pt_r.org[(k+1+j)%3]});
        inb[k][j]  = (lo_d[k][j] <= $signed(pt_r.ps[k][j])) &&
                     ($signed(pt_r.ps[k][j]) <= hi_d[k][j]);
      end
      hit_nxt = hit_nxt || (pt_r.face_ok[k] && inb[k][0] && inb[k][1]);
    end
    if (pt_r.op == rbh_pkg::OP_CLAMP) begin
      hit_nxt  = 1'b0;
      near_nxt = pt_r.near;
    end else begin
      near_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mt_r       <= mt_nxt;
      pt_r       <= pt_nxt;
      out_hit_r  <= hit_nxt;
      out_near_r <= near_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mt_vld_r    <= 1'b0;
      pt_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      mt_vld_r    <= vld_r[NS];
      pt_vld_r    <= mt_vld_r;
      out_valid_r <= pt_vld_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_hit   = out_hit_r;
  assign out_near  = out_near_r;

endmodule

// ===== tb/ray_box_hit_and_clamp_tb.sv =====
`timescale 1ns / 1ps

module ray_box_hit_and_clamp_tb;

  localparam int CW = 32;
  localparam int SETTLE_CYCLES = CW + 8;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam logic [rbh_pkg::CFG_IDX_W-1:0] REG_SPARE_A = 3'd6;
  localparam logic [rbh_pkg::CFG_IDX_W-1:0] REG_SPARE_B = 3'd7;
  localparam logic signed [CW-1:0] C_MIN = 32'sh8000_0000;
  localparam logic signed [CW-1:0] C_MAX = 32'sh7fff_ffff;
  localparam logic signed [CW-1:0] ONE = 32'sh0001_0000;

  typedef logic signed [CW-1:0] coord_t;
  typedef logic signed [127:0] wide_t;

  typedef struct {
    logic   op;
    coord_t org [3];
    coord_t dir [3];
  } ray_item_t;

  typedef struct {
    logic   hit;
    coord_t near [3];
  } box_result_t;

  class box_scoreboard;
    coord_t      box_lo [3];
    coord_t      box_hi [3];
    box_result_t pending [$];
    int          mismatches;

    function new();
      foreach (box_lo[i]) begin
        box_lo[i] = '0;
        box_hi[i] = '0;
      end
      mismatches = 0;
    endfunction

    function void write_reg(logic [rbh_pkg::CFG_IDX_W-1:0] idx, coord_t val);
      case (idx)
        rbh_pkg::REG_MIN_X: box_lo[0] = val;
        rbh_pkg::REG_MIN_Y: box_lo[1] = val;
        rbh_pkg::REG_MIN_Z: box_lo[2] = val;
        rbh_pkg::REG_MAX_X: box_hi[0] = val;
        rbh_pkg::REG_MAX_Y: box_hi[1] = val;
        rbh_pkg::REG_MAX_Z: box_hi[2] = val;
        default: ;
      endcase
    endfunction

    function logic ray_meets_box(ray_item_t it);
      wide_t plane, t, h;
      logic  ok;
      int    a;
      if (it.org[0] >= box_lo[0] && it.org[0] <= box_hi[0] &&
          it.org[1] >= box_lo[1] && it.org[1] <= box_hi[1] &&
          it.org[2] >= box_lo[2] && it.org[2] <= box_hi[2])
        return 1'b1;
      for (int k = 0; k < 3; k++) begin
        if (it.dir[k] == 0) continue;
        plane = (it.dir[k] < 0) ? wide_t'(box_hi[k]) : wide_t'(box_lo[k]);
        t = ((plane - wide_t'(it.org[k])) * 65536) / wide_t'(it.dir[k]);
        if (t < 0) continue;
        if (t > wide_t'(C_MAX)) t = wide_t'(C_MAX);
        ok = 1'b1;
        for (int j = 1; j < 3; j++) begin
          a = (k + j) % 3;
          h = wide_t'(it.org[a]) + (t * wide_t'(it.dir[a])) / 65536;
          if (h < wide_t'(box_lo[a]) || h > wide_t'(box_hi[a])) ok = 1'b0;
        end
        if (ok) return 1'b1;
      end
      return 1'b0;
    endfunction

    function void note_input(ray_item_t it);
      box_result_t r;
      r.hit = 1'b0;
      foreach (r.near[i]) r.near[i] = '0;
      if (it.op == rbh_pkg::OP_HIT) begin
        r.hit = ray_meets_box(it);
      end else begin
        foreach (r.near[i]) begin
          if (it.org[i] < box_lo[i]) r.near[i] = box_lo[i];
          else if (it.org[i] > box_hi[i]) r.near[i] = box_hi[i];
          else r.near[i] = it.org[i];
        end
      end
      pending.push_back(r);
    endfunction

    function void check_result(box_result_t got);
      box_result_t want;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result: hit %0b near %0d %0d %0d",
                                       got.hit, got.near[0], got.near[1], got.near[2]);
        return;
      end
      want = pending.pop_front();
      if (got.hit !== want.hit || got.near[0] !== want.near[0] ||
          got.near[1] !== want.near[1] || got.near[2] !== want.near[2]) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: exp hit %0b near %0d %0d %0d, got hit %0b near %0d %0d %0d",
                   want.hit, want.near[0], want.near[1], want.near[2],
                   got.hit, got.near[0], got.near[1], got.near[2]);
      end
    endfunction
  endclass

  logic            clk = 1'b0;
  logic            rst_n = 1'b0;
  logic            cfg_we = 1'b0;
  logic [rbh_pkg::CFG_IDX_W-1:0] cfg_idx = '0;
  logic [CW-1:0]   cfg_wdata = '0;
  logic            in_valid = 1'b0;
  logic            in_ready;
  logic            in_op = 1'b0;
  logic [CW-1:0]   in_org_x = '0, in_org_y = '0, in_org_z = '0;
  logic [CW-1:0]   in_dir_x = '0, in_dir_y = '0, in_dir_z = '0;
  logic            out_valid;
  logic            out_ready = 1'b0;
  logic            out_hit;
  logic [CW-1:0]   out_near_x, out_near_y, out_near_z;

  box_scoreboard   sb = new();
  logic            idle_on = 1'b1;
  int              stuck_cycles = 0;

  always #10 clk = ~clk;

  ray_box_hit_and_clamp #(.COORD_WIDTH(CW)) i_dut (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_wdata(cfg_wdata),
    .in_valid(in_valid), .in_ready(in_ready), .in_op(in_op),
    .in_org_x(in_org_x), .in_org_y(in_org_y), .in_org_z(in_org_z),
    .in_dir_x(in_dir_x), .in_dir_y(in_dir_y), .in_dir_z(in_dir_z),
    .out_valid(out_valid), .out_ready(out_ready), .out_hit(out_hit),
    .out_near_x(out_near_x), .out_near_y(out_near_y), .out_near_z(out_near_z)
  );

  always @(posedge clk) begin
    ray_item_t   it;
    box_result_t r;
    if (rst_n && in_valid && in_ready) begin
      it.op = in_op;
      it.org[0] = in_org_x; it.org[1] = in_org_y; it.org[2] = in_org_z;
      it.dir[0] = in_dir_x; it.dir[1] = in_dir_y; it.dir[2] = in_dir_z;
      sb.note_input(it);
    end
    if (rst_n && out_valid && out_ready) begin
      r.hit = out_hit;
      r.near[0] = out_near_x; r.near[1] = out_near_y; r.near[2] = out_near_z;
      sb.check_result(r);
    end
  end

  always @(posedge clk) begin
    out_ready <= idle_on ? ($urandom_range(99) >= 31) : 1'b1;
  end

  always @(posedge clk) begin
    if (rst_n && ((in_valid && in_ready) || (out_valid && out_ready))) stuck_cycles <= 0;
    else if (rst_n) stuck_cycles <= stuck_cycles + 1;
    if (stuck_cycles >= WATCHDOG_LIMIT) begin
      $display("ray_box_hit_and_clamp_tb failed");
      $finish;
    end
  end

  task automatic set_reg(logic [rbh_pkg::CFG_IDX_W-1:0] idx, coord_t val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_wdata <= val;
    sb.write_reg(idx, val);
  endtask

  task automatic set_box(coord_t lx, coord_t ly, coord_t lz, coord_t hx, coord_t hy, coord_t hz);
    set_reg(rbh_pkg::REG_MIN_X, lx);
    set_reg(rbh_pkg::REG_MIN_Y, ly);
    set_reg(rbh_pkg::REG_MIN_Z, lz);
    set_reg(rbh_pkg::REG_MAX_X, hx);
    set_reg(rbh_pkg::REG_MAX_Y, hy);
    set_reg(rbh_pkg::REG_MAX_Z, hz);
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic send(ray_item_t it);
    while (idle_on && $urandom_range(99) < 31) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_op <= it.op;
    in_org_x <= it.org[0]; in_org_y <= it.org[1]; in_org_z <= it.org[2];
    in_dir_x <= it.dir[0]; in_dir_y <= it.dir[1]; in_dir_z <= it.dir[2];
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic send_ray(logic op, coord_t ox, coord_t oy, coord_t oz,
                          coord_t dx, coord_t dy, coord_t dz);
    ray_item_t it;
    it.op = op;
    it.org[0] = ox; it.org[1] = oy; it.org[2] = oz;
    it.dir[0] = dx; it.dir[1] = dy; it.dir[2] = dz;
    send(it);
  endtask

  function automatic coord_t near_coord();
    return coord_t'($urandom_range(0, 128 * 65536)) - 64 * ONE;
  endfunction

  function automatic coord_t any_coord();
    case ($urandom_range(4))
      0: return coord_t'($urandom());
      1: case ($urandom_range(4))
           0: return C_MIN;
           1: return C_MAX;
           2: return 0;
           3: return -1;
           default: return 1;
         endcase
      default: return near_coord();
    endcase
  endfunction

  task automatic random_items(int count);
    ray_item_t it;
    coord_t    aim;
    int        sh;
    repeat (count) begin
      it.op = ($urandom_range(99) < 25) ? rbh_pkg::OP_CLAMP : rbh_pkg::OP_HIT;
      if (it.op == rbh_pkg::OP_HIT && $urandom_range(99) < 70) begin
        sh = $urandom_range(0, 4);
        for (int a = 0; a < 3; a++) begin
          if (sb.box_hi[a] >= sb.box_lo[a])
            aim = sb.box_lo[a] + coord_t'($urandom_range(0, 32'(sb.box_hi[a] - sb.box_lo[a])));
          else
            aim = sb.box_lo[a];
          it.org[a] = aim + near_coord();
          it.dir[a] = (aim - it.org[a]) >>> sh;
          if ($urandom_range(99) < 10) it.dir[a] = 0;
        end
      end else begin
        foreach (it.org[a]) begin
          it.org[a] = any_coord();
          it.dir[a] = any_coord();
        end
      end
      send(it);
    end
  endtask

  task automatic random_box();
    coord_t lo [3];
    coord_t hi [3];
    foreach (lo[a]) begin
      lo[a] = near_coord();
      hi[a] = lo[a] + coord_t'($urandom_range(0, 32 * 65536));
    end
    if ($urandom_range(3) == 0) hi[$urandom_range(2)] = lo[0] - ONE;
    set_box(lo[0], lo[1], lo[2], hi[0], hi[1], hi[2]);
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // reset box: a single point at the origin
    send_ray(rbh_pkg::OP_HIT, 0, 0, 0, 0, 0, 0);
    send_ray(rbh_pkg::OP_HIT, ONE, 0, 0, 0, 0, 0);
    send_ray(rbh_pkg::OP_HIT, ONE, 0, 0, -ONE, 0, 0);
    send_ray(rbh_pkg::OP_CLAMP, C_MIN, C_MAX, -1, C_MAX, C_MIN, 0);
    drain();

    set_box(-10 * ONE, -10 * ONE, -10 * ONE, 10 * ONE, 10 * ONE, 10 * ONE);
    set_reg(REG_SPARE_A, C_MAX);
    set_reg(REG_SPARE_B, C_MIN);
    @(posedge clk);
    cfg_we <= 1'b0;
    send_ray(rbh_pkg::OP_HIT, 0, 0, 0, 0, 0, 0);
    send_ray(rbh_pkg::OP_HIT, 10 * ONE, -10 * ONE, 10 * ONE, 0, 0, 0);
    send_ray(rbh_pkg::OP_HIT, -20 * ONE, 0, 0, ONE, 0, 0);
    send_ray(rbh_pkg::OP_HIT, 20 * ONE, 0, 0, -ONE, 0, 0);
    send_ray(rbh_pkg::OP_HIT, 20 * ONE, 0, 0, ONE, 0, 0);
    send_ray(rbh_pkg::OP_HIT, 0, 30 * ONE, 0, 0, -ONE, ONE);
    send_ray(rbh_pkg::OP_HIT, 0, 0, -30 * ONE, ONE, 0, ONE);
    send_ray(rbh_pkg::OP_HIT, 20 * ONE, 20 * ONE, 20 * ONE, 0, 0, 0);
    send_ray(rbh_pkg::OP_HIT, -10 * ONE - 1, 0, 0, C_MAX, 0, 0);
    send_ray(rbh_pkg::OP_HIT, -10 * ONE - 1, 0, 0, C_MIN, 5, 0);
    send_ray(rbh_pkg::OP_HIT, C_MIN, 0, 0, 1, 1, 1);
    send_ray(rbh_pkg::OP_HIT, C_MAX, C_MAX, C_MAX, C_MIN, C_MIN, C_MIN);
    send_ray(rbh_pkg::OP_CLAMP, C_MIN, 3 * ONE, C_MAX, C_MAX, C_MAX, C_MAX);
    drain();

    set_box(C_MIN, C_MIN, C_MIN, C_MAX, C_MAX, C_MAX);
    send_ray(rbh_pkg::OP_HIT, C_MIN, C_MAX, 0, -1, 1, 0);
    send_ray(rbh_pkg::OP_CLAMP, C_MIN, C_MAX, 0, 0, 0, 0);
    drain();

    set_box(C_MAX, 5 * ONE, -ONE, C_MIN, -5 * ONE, ONE);
    send_ray(rbh_pkg::OP_HIT, 0, 0, 0, ONE, ONE, ONE);
    send_ray(rbh_pkg::OP_CLAMP, 0, 0, 0, 0, 0, 0);
    send_ray(rbh_pkg::OP_CLAMP, C_MAX, C_MIN, 2 * ONE, 0, 0, 0);
    random_items(40);
    drain();

    for (int ph = 0; ph < 6; ph++) begin
      idle_on <= (ph != 2);
      random_box();
      random_items(100);
      drain();
    end
    idle_on <= 1'b1;

    if (sb.mismatches == 0 && sb.pending.size() == 0) begin
      $display("ray_box_hit_and_clamp_tb passed");
    end else begin
      $display("ray_box_hit_and_clamp_tb failed");
    end
    $finish;
  end
endmodule
